// ===== design/pal_pkg.sv =====
`default_nettype none

package pal_pkg;

	// command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_READ   = 2'd1;
	localparam logic [1:0] CMD_FIND   = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_BAD_POS   = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic        ins_en;    // insert this cycle
		logic        scan_read; // scan looks for a position, not a value
		logic [31:0] word;      // insert value or search key
	} pal_ctl_t;

	// scan front, handed from cell to cell
	typedef struct packed {
		logic        hit;
		logic [31:0] data;
		logic [4:0]  fpos;
	} pal_probe_t;

endpackage

`default_nettype wire

// ===== design/positional_array_list.sv =====
`default_nettype none

// Channel  | Signals                                   | Handshake
// ---------+-------------------------------------------+---------------------------------
// request  | cmd, position, value                      | taken when start & !busy
// result   | status, read_value, found_position,       | done high one cycle, no stall
//          | list_length                               |
//
// Insert, unused code, bad position, find on an empty list: result in the
// cycle after the request, busy stays low, a new request may follow at once.
// Other reads and finds: a scan front walks the cells one per cycle; busy is
// high through S_SCAN and S_DONE, and the result is registered in S_DONE.
// Reset clears the element count and the controller; list contents are
// undefined until inserted. The receiver cannot stall results.

module positional_array_list #(
	parameter int DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  cmd,
	input  wire  [4:0]  position,
	input  wire  [31:0] value,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] read_value,
	output logic [4:0]  found_position,
	output logic [4:0]  list_length
);
	import pal_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);          // count width
	localparam int IW = $clog2(DEPTH);              // scan counter width
	localparam int PW = ((CW > 5) ? CW : 5) + 1;    // compare width
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [IW-1:0] LAST_C  = IW'(DEPTH - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  count_q;
	logic [IW-1:0]  scan_q;
	logic [31:0]    key_q;
	logic           read_q;
	logic [CW-1:0]  launch_q;
	logic           done_q;
	logic [1:0]     status_q;
	logic [31:0]    read_value_q;
	logic [4:0]     found_q;
	logic [4:0]     length_q;

	logic           accept;
	logic [PW-1:0]  pos_w;
	logic [PW-1:0]  cnt_w;
	logic           ins_ok;
	logic           launch;
	logic [CW-1:0]  launch_rem;
	logic [1:0]     imm_status;
	logic [CW-1:0]  ins_idx;
	pal_ctl_t       ctl;

	// cell row wiring
	pal_probe_t     tok   [DEPTH+1];
	logic [CW-1:0]  rem   [DEPTH+1];
	logic [31:0]    elem  [DEPTH];
	logic [31:0]    left  [DEPTH];

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign pos_w  = PW'(position);
	assign cnt_w  = PW'(count_q);

	// request decode: decide immediate result or scan launch
	always_comb begin
		ins_ok     = 1'b0;
		launch     = 1'b0;
		launch_rem = '0;
		imm_status = STAT_OK;
		unique case (cmd)
			CMD_INSERT: begin
				if (position == 5'd0 || pos_w > cnt_w + PW'(1)) begin
					imm_status = STAT_BAD_POS;
				end else if (count_q == DEPTH_C) begin
					imm_status = STAT_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			CMD_READ: begin
				if (position == 5'd0 || pos_w > cnt_w) begin
					imm_status = STAT_BAD_POS;
				end else begin
					launch     = 1'b1;
					launch_rem = CW'(pos_w);
				end
			end
			CMD_FIND: begin
				if (count_q == '0) begin
					imm_status = STAT_NOT_FOUND;
				end else begin
					launch     = 1'b1;
					launch_rem = count_q;
				end
			end
			default: begin
				imm_status = STAT_OK;
			end
		endcase
	end

	// valid inserts have position <= DEPTH, so position-1 fits the count width
	assign ins_idx       = CW'(pos_w - PW'(1));
	assign ctl.ins_en    = accept && ins_ok;
	assign ctl.scan_read = read_q;
	assign ctl.word      = (state_q == S_IDLE) ? value : key_q;

	// scan front enters cell 0 the cycle after the request is taken
	assign tok[0] = '0;
	assign rem[0] = launch_q;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign left[g] = ctl.word;
		end else begin : g_rest
			assign left[g] = elem[g-1];
		end

		pal_cell #(
			.CW  (CW),
			.IDX (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.ins_idx   (ins_idx),
			.elem_left (left[g]),
			.elem      (elem[g]),
			.tok_in    (tok[g]),
			.rem_in    (rem[g]),
			.tok_out   (tok[g+1]),
			.rem_out   (rem[g+1])
		);
	end

	// controller and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			scan_q       <= '0;
			key_q        <= '0;
			read_q       <= 1'b0;
			launch_q     <= '0;
			done_q       <= 1'b0;
			status_q     <= STAT_OK;
			read_value_q <= '0;
			found_q      <= '0;
			length_q     <= '0;
		end else begin
			done_q   <= 1'b0;
			launch_q <= '0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (launch) begin
							state_q  <= S_SCAN;
							scan_q   <= '0;
							key_q    <= value;
							read_q   <= (cmd == CMD_READ);
							launch_q <= launch_rem;
						end else begin
							done_q       <= 1'b1;
							status_q     <= imm_status;
							read_value_q <= '0;
							found_q      <= '0;
							if (ins_ok) begin
								count_q  <= count_q + CW'(1);
								length_q <= 5'(count_q + CW'(1));
							end else begin
								length_q <= 5'(count_q);
							end
						end
					end
				end
				S_SCAN: begin
					if (scan_q == LAST_C) begin
						state_q <= S_DONE;
					end else begin
						scan_q <= scan_q + IW'(1);
					end
				end
				S_DONE: begin
					// front has left the last cell
					state_q      <= S_IDLE;
					done_q       <= 1'b1;
					length_q     <= 5'(count_q);
					read_value_q <= read_q ? tok[DEPTH].data : '0;
					found_q      <= read_q ? 5'd0 : tok[DEPTH].fpos;
					if (read_q || tok[DEPTH].hit) begin
						status_q <= STAT_OK;
					end else begin
						status_q <= STAT_NOT_FOUND;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign read_value     = read_value_q;
	assign found_position = found_q;
	assign list_length    = length_q;

`ifndef NO_ASSERTIONS
	// count never exceeds capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("element count above capacity");

	// count moves only on an accepted insert request
	a_count_src: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(accept && cmd == CMD_INSERT))
		else $error("count changed without an insert");

	// every finished scan gives a result
	a_scan_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> done)
		else $error("scan ended with no result");

	// reported length follows the count
	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> list_length == 5'(count_q))
		else $error("list length differs from count");
`endif

endmodule

`default_nettype wire

// ===== design/pal_cell.sv =====
`default_nettype none

module pal_cell #(
	parameter int CW  = 5,
	parameter int IDX = 0
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  pal_pkg::pal_ctl_t       ctl,
	input  wire        [CW-1:0]     ins_idx,
	input  wire        [31:0]       elem_left,
	output logic       [31:0]       elem,
	input  pal_pkg::pal_probe_t     tok_in,
	input  wire        [CW-1:0]     rem_in,
	output pal_pkg::pal_probe_t     tok_out,
	output logic       [CW-1:0]     rem_out
);
	import pal_pkg::*;

	localparam logic [CW-1:0] MY   = CW'(IDX);
	localparam logic [4:0]    FPOS = 5'(IDX + 1);

	logic [31:0]  elem_q;
	logic         matched;
	pal_probe_t   tok_q;
	logic [CW-1:0] rem_q;

	// insert: load at the target, take the left neighbour's word above it
	always_ff @(posedge clk) begin
		if (ctl.ins_en) begin
			if (ins_idx == MY) begin
				elem_q <= ctl.word;
			end else if (ins_idx < MY) begin
				elem_q <= elem_left;
			end
		end
	end

	always_comb begin
		if (ctl.scan_read) begin
			matched = !tok_in.hit && (rem_in == CW'(1));
		end else begin
			matched = !tok_in.hit && (rem_in != '0) && (elem_q == ctl.word);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			rem_q <= '0;
		end else begin
			tok_q.hit  <= tok_in.hit | matched;
			tok_q.data <= matched ? elem_q : tok_in.data;
			tok_q.fpos <= matched ? FPOS : tok_in.fpos;
			rem_q      <= (rem_in == '0) ? '0 : rem_in - CW'(1);
		end
	end

	assign elem    = elem_q;
	assign tok_out = tok_q;
	assign rem_out = rem_q;

endmodule

`default_nettype wire
